FILE: src/ecs_pkg.sv
// ecs_pkg: types and constants for the encoder count extender and speed estimator
// no dependencies; imported by encoder_count_extend_speed
package ecs_pkg;

  localparam int FRAC_BITS = 8;

  localparam int CNT_W  = 32;
  localparam int RAW_W  = 16;
  localparam int CPR_W  = 16;
  localparam int PROD_W = CNT_W + CPR_W;
  localparam int NUM_W  = 64;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_EXTEND = 2'd0;
  localparam logic [1:0] OP_SPEED  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [CPR_W-1:0] CPS_SCALE = 16'd1000;
  localparam logic [CPR_W-1:0] RPM_SCALE = 16'd60000;

  localparam logic [CNT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [RAW_W-1:0] raw_count;
    logic [CNT_W-1:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] position;
    logic signed [CNT_W-1:0] speed_rpm_q8;
    logic signed [CNT_W-1:0] speed_cps_q8;
    logic                    speed_updated;
  } out_item_t;

endpackage

FILE: src/encoder_count_extend_speed.sv
// encoder_count_extend_speed: position extender and speed estimator, top level
// depends on ecs_pkg (types, constants); one shared multiplier and serial divider
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_ready_o    | in_data_i  (ecs_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i  | out_data_o (ecs_pkg::out_item_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_data_i (counts_per_rev)
//
// extend, clear, unused and zero-elapsed speed items: result registered in the cycle
//   after accept, one per cycle while the output register is free; speed items with nonzero
//   elapsed time: three passes through the shared 32x16 multiplier, two 32-step restoring
//   divisions on the shared subtractor, cut short on overflow; in_ready_o is low meanwhile
// reset clears all state to zero and counts_per_rev to one; no clearing pass
// a stalled result sits in the output register; a second result waits in the
//   sequencer, with in_ready_o low, until the register frees up
module encoder_count_extend_speed (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ecs_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ecs_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import ecs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_CPS, ST_MUL_RPM, ST_MUL_DEN, ST_LOAD, ST_TEST, ST_RUN, ST_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [CPR_W-1:0]  cpr_q, cpr_d;
  logic [RAW_W-1:0]  last_raw_q, last_raw_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  ref_q, ref_d;
  logic [CNT_W-1:0]  last_time_q, last_time_d;
  logic [CNT_W-1:0]  rpm_q, rpm_d;
  logic [CNT_W-1:0]  cps_q, cps_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  mag_q, mag_d;
  logic [CNT_W-1:0]  dt_q, dt_d;
  logic [PROD_W-1:0] cps_num_q, cps_num_d;
  logic [PROD_W-1:0] rpm_num_q, rpm_num_d;
  logic [PROD_W-1:0] rpm_den_q, rpm_den_d;
  logic              sel_q, sel_d;
  logic [PROD_W:0]   rem_q, rem_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              upd_q, upd_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              in_acc, slot_free, speed_go;
  logic [RAW_W-1:0]  d16;
  logic [CNT_W-1:0]  total_next, dt_now, delta;
  logic [CNT_W-1:0]  mul_a;
  logic [CPR_W-1:0]  mul_b, cpr_eff;
  logic [PROD_W-1:0] mul_p, den;
  logic [NUM_W-1:0]  num64;
  logic [PROD_W:0]   sub_a;
  logic [PROD_W+1:0] diff;
  logic              borrow;
  logic [CNT_W-1:0]  q_fin, q_sat;

  function automatic logic [CNT_W-1:0] saturate(input logic neg, input logic ovf,
                                                input logic [CNT_W-1:0] q);
    logic [CNT_W-1:0] r;
    if (ovf || q[CNT_W-1]) begin
      r = neg ? SAT_NEG : SAT_POS;
    end else begin
      r = neg ? (CNT_W'(0) - q) : q;
    end
    return r;
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  // wrapped raw difference, sign extended
  assign d16        = RAW_W'(in_data_i.raw_count) - last_raw_q;
  assign total_next = total_q + {{(CNT_W-RAW_W){d16[RAW_W-1]}}, d16};
  assign dt_now     = in_data_i.now_ms - last_time_q;
  assign delta      = total_next - ref_q;
  assign speed_go   = (in_data_i.operation == OP_SPEED) && (dt_now != '0);

  assign cpr_eff = (cpr_q == '0) ? CPR_W'(1) : cpr_q;

  // shared multiplier
  always_comb begin
    mul_a = mag_q;
    mul_b = CPS_SCALE;
    case (state_q)
      ST_MUL_RPM: mul_b = RPM_SCALE;
      ST_MUL_DEN: begin
        mul_a = dt_q;
        mul_b = cpr_eff;
      end
      default: mul_b = CPS_SCALE;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // shared subtractor of the divider
  assign den    = sel_q ? rpm_den_q : PROD_W'(dt_q);
  assign num64  = NUM_W'(sel_q ? rpm_num_q : cps_num_q) << FRAC_BITS;
  assign sub_a  = (state_q == ST_RUN) ? {rem_q[PROD_W-1:0], lo_q[CNT_W-1]} : rem_q;
  assign diff   = {1'b0, sub_a} - {2'b00, den};
  assign borrow = diff[PROD_W+1];
  assign q_fin  = {quo_q[CNT_W-2:0], !borrow};
  assign q_sat  = saturate(neg_q, (state_q == ST_TEST), q_fin);

  always_comb begin
    state_d     = state_q;
    cpr_d       = cpr_q;
    last_raw_d  = last_raw_q;
    total_d     = total_q;
    ref_d       = ref_q;
    last_time_d = last_time_q;
    rpm_d       = rpm_q;
    cps_d       = cps_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    dt_d        = dt_q;
    cps_num_d   = cps_num_q;
    rpm_num_d   = rpm_num_q;
    rpm_den_d   = rpm_den_q;
    sel_d       = sel_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    upd_d       = upd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (cfg_valid_i && cfg_ready_o) begin
      cpr_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.operation) inside
            OP_EXTEND, OP_SPEED: begin
              total_d    = total_next;
              last_raw_d = RAW_W'(in_data_i.raw_count);
            end
            OP_CLEAR: begin
              total_d    = '0;
              last_raw_d = '0;
            end
            default: ;
          endcase
          if (speed_go) begin
            neg_d       = delta[CNT_W-1];
            mag_d       = delta[CNT_W-1] ? (CNT_W'(0) - delta) : delta;
            dt_d        = dt_now;
            ref_d       = total_next;
            last_time_d = in_data_i.now_ms;
            state_d     = ST_MUL_CPS;
          end else if (slot_free) begin
            out_valid_d       = 1'b1;
            out_d.position    = total_d;
            out_d.speed_rpm_q8 = rpm_q;
            out_d.speed_cps_q8 = cps_q;
            out_d.speed_updated = 1'b0;
          end else begin
            upd_d   = 1'b0;
            state_d = ST_OUT;
          end
        end
      end
      ST_MUL_CPS: begin
        cps_num_d = mul_p;
        state_d   = ST_MUL_RPM;
      end
      ST_MUL_RPM: begin
        rpm_num_d = mul_p;
        state_d   = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        rpm_den_d = mul_p;
        sel_d     = 1'b0;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        rem_d   = (PROD_W+1)'(num64[NUM_W-1:CNT_W]);
        lo_d    = num64[CNT_W-1:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = ST_TEST;
      end
      ST_TEST, ST_RUN: begin
        if (state_q == ST_RUN) begin
          rem_d = borrow ? sub_a : diff[PROD_W:0];
          lo_d  = lo_q << 1;
          quo_d = q_fin;
          cnt_d = cnt_q + STEP_W'(1);
        end
        // quotient overflow when the high half already reaches the divisor
        if ((state_q == ST_TEST && !borrow) ||
            (state_q == ST_RUN && cnt_q == STEP_W'(DIV_STEPS - 1))) begin
          if (!sel_q) begin
            cps_d   = q_sat;
            sel_d   = 1'b1;
            state_d = ST_LOAD;
          end else begin
            rpm_d   = q_sat;
            upd_d   = 1'b1;
            state_d = ST_OUT;
          end
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.position     = total_q;
          out_d.speed_rpm_q8 = rpm_q;
          out_d.speed_cps_q8 = cps_q;
          out_d.speed_updated = upd_q;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cpr_q       <= CPR_W'(1);
      last_raw_q  <= '0;
      total_q     <= '0;
      ref_q       <= '0;
      last_time_q <= '0;
      rpm_q       <= '0;
      cps_q       <= '0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      dt_q        <= '0;
      cps_num_q   <= '0;
      rpm_num_q   <= '0;
      rpm_den_q   <= '0;
      sel_q       <= 1'b0;
      rem_q       <= '0;
      lo_q        <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cpr_q       <= cpr_d;
      last_raw_q  <= last_raw_d;
      total_q     <= total_d;
      ref_q       <= ref_d;
      last_time_q <= last_time_d;
      rpm_q       <= rpm_d;
      cps_q       <= cps_d;
      neg_q       <= neg_d;
      mag_q       <= mag_d;
      dt_q        <= dt_d;
      cps_num_q   <= cps_num_d;
      rpm_num_q   <= rpm_num_d;
      rpm_den_q   <= rpm_den_d;
      sel_q       <= sel_d;
      rem_q       <= rem_d;
      lo_q        <= lo_d;
      quo_q       <= quo_d;
      cnt_q       <= cnt_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // restoring divider keeps the partial remainder below the divisor
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rem_q < {1'b0, den}))
    else $error("partial remainder not below divisor");

  a_busy_after_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && speed_go) |=> !in_ready_o)
    else $error("ready during speed computation");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !speed_go && slot_free) |=> (out_valid_o && !out_data_o.speed_updated))
    else $error("quick item result missing");

  a_updated_only_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && !out_ready_i) && out_data_o.speed_updated)
      |-> $past(state_q == ST_OUT))
    else $error("speed update reported without computation");

endmodule

FILE: verif/encoder_count_extend_speed_tb.sv
// encoder_count_extend_speed_tb: self-checking testbench for the encoder position extender
// and speed estimator; depends on ecs_pkg and encoder_count_extend_speed
module encoder_count_extend_speed_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ecs_pkg::*;

  localparam int          PERIOD      = 20;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          RAMP_ITEMS  = 64;
  localparam int          PHASE_ITEMS = 210;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  class position_speed_checker;
    logic [15:0] cpr;
    logic [15:0] prev_raw;
    logic [31:0] pos_total;
    logic [31:0] speed_ref;
    logic [31:0] ref_time;
    logic [31:0] rpm_q8;
    logic [31:0] cps_q8;
    out_item_t   pending_readings[$];
    int unsigned fails;

    function new();
      cpr       = 16'd1;
      prev_raw  = '0;
      pos_total = '0;
      speed_ref = '0;
      ref_time  = '0;
      rpm_q8    = '0;
      cps_q8    = '0;
      fails     = 0;
    endfunction

    function int outstanding();
      return pending_readings.size();
    endfunction

    function void extend_pos(logic [15:0] raw);
      logic [15:0] d16;
      d16 = raw - prev_raw;
      pos_total = pos_total + {{16{d16[15]}}, d16};
      prev_raw = raw;
    endfunction

    function logic [31:0] sat_quot(bit neg, logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      q = num / den;
      if (neg) begin
        if (q >= 64'h8000_0000) return SAT_NEG;
        return -q[31:0];
      end
      if (q > 64'h7FFF_FFFF) return SAT_POS;
      return q[31:0];
    endfunction

    function void note_item(in_item_t it);
      logic [31:0] dt;
      logic [31:0] dpos;
      logic [31:0] mag;
      logic [63:0] cpr_eff;
      bit          neg;
      bit          upd;
      out_item_t   want;
      upd = 1'b0;
      case (it.operation)
        OP_EXTEND: extend_pos(it.raw_count);
        OP_SPEED: begin
          extend_pos(it.raw_count);
          dt = it.now_ms - ref_time;
          if (dt != 0) begin
            dpos    = pos_total - speed_ref;
            neg     = dpos[31];
            mag     = neg ? -dpos : dpos;
            cpr_eff = (cpr == 16'd0) ? 64'd1 : {48'd0, cpr};
            cps_q8  = sat_quot(neg, ({32'd0, mag} * 64'd1000) << FRAC_BITS, {32'd0, dt});
            rpm_q8  = sat_quot(neg, ({32'd0, mag} * 64'd60000) << FRAC_BITS,
                               {32'd0, dt} * cpr_eff);
            speed_ref = pos_total;
            ref_time  = it.now_ms;
            upd       = 1'b1;
          end
        end
        OP_CLEAR: begin
          pos_total = '0;
          prev_raw  = '0;
        end
        default: ;
      endcase
      want.position      = pos_total;
      want.speed_rpm_q8  = rpm_q8;
      want.speed_cps_q8  = cps_q8;
      want.speed_updated = upd;
      pending_readings.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_readings.size() == 0) begin
        $error("result with no item pending: position %0d", got.position);
        fails++;
        return;
      end
      want = pending_readings.pop_front();
      if (got.position !== want.position) begin
        $error("position expected %0d actual %0d", want.position, got.position);
        fails++;
      end
      if (got.speed_rpm_q8 !== want.speed_rpm_q8) begin
        $error("speed_rpm_q8 expected %0d actual %0d", want.speed_rpm_q8, got.speed_rpm_q8);
        fails++;
      end
      if (got.speed_cps_q8 !== want.speed_cps_q8) begin
        $error("speed_cps_q8 expected %0d actual %0d", want.speed_cps_q8, got.speed_cps_q8);
        fails++;
      end
      if (got.speed_updated !== want.speed_updated) begin
        $error("speed_updated expected %0d actual %0d", want.speed_updated,
               got.speed_updated);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  position_speed_checker sb = new();

  bit          gaps_on = 1'b1;
  bit          hold_off_req = 1'b0;
  logic [15:0] walk_raw = '0;
  logic [31:0] walk_time = '0;
  int unsigned cycle_count = 0;

  encoder_count_extend_speed DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t mk(logic [1:0] op, logic [15:0] raw, logic [31:0] now);
    in_item_t it;
    it.operation = op;
    it.raw_count = raw;
    it.now_ms    = now;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.operation = (r < 45) ? OP_SPEED : (r < 85) ? OP_EXTEND : (r < 93) ? OP_CLEAR : OP_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 70) walk_raw = walk_raw + 16'($urandom_range(0, 600)) - 16'd300;
    else if (r < 85) walk_raw = walk_raw + ($urandom_range(0, 1) ? 16'd32767 : 16'd32769);
    else walk_raw = 16'($urandom);
    it.raw_count = walk_raw;
    r = $urandom_range(0, 99);
    if (it.operation != OP_SPEED) begin
      it.now_ms = (r < 50) ? walk_time : $urandom;
    end else begin
      if (r < 80) walk_time = walk_time + $urandom_range(1, 60);
      else if (r >= 90) walk_time = $urandom;
      it.now_ms = walk_time;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    if (gaps_on && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_cpr(input logic [15:0] value);
    drain();
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.cpr = value;
  endtask

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_item(rand_item());
    end
  endtask

  initial begin : result_side
    int unsigned stall;
    stall = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 99) < 20) begin
        out_ready_i <= 1'b0;
        stall = gap_len() - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] ramp_raw;
    logic [31:0] ramp_t;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, zero elapsed time, saturation, time wrap, clear
    send_item(mk(OP_EXTEND, 16'h7FFF, 32'h0));
    send_item(mk(OP_EXTEND, 16'h8000, 32'h0));
    send_item(mk(OP_SPEED,  16'h8000, 32'h0));
    send_item(mk(OP_SPEED,  16'h8001, 32'h1));
    send_item(mk(OP_UNUSED, 16'h04D2, 32'd77));
    send_item(mk(OP_EXTEND, 16'h0000, 32'h0));
    send_item(mk(OP_EXTEND, 16'h8001, 32'h0));
    send_item(mk(OP_EXTEND, 16'h0002, 32'h0));
    send_item(mk(OP_EXTEND, 16'h8003, 32'h0));
    send_item(mk(OP_SPEED,  16'h0004, 32'h2));
    send_item(mk(OP_CLEAR,  16'h7FFF, 32'hFFFF_FFFF));
    send_item(mk(OP_SPEED,  16'h0000, 32'hFFFF_FFF0));
    send_item(mk(OP_SPEED,  16'h0064, 32'h0000_0010));
    send_item(mk(OP_SPEED,  16'h0000, 32'd1016));
    send_item(mk(OP_SPEED,  16'h0003, 32'd1023));
    send_item(mk(OP_SPEED,  16'hFFFD, 32'd1030));
    send_item(mk(OP_SPEED,  16'hFFFD, 32'd1030));
    send_item(mk(OP_CLEAR,  16'h0000, 32'h0));
    send_item(mk(OP_EXTEND, 16'hFFFF, 32'h5555_5555));
    send_item(mk(OP_UNUSED, 16'hAAAA, 32'hAAAA_AAAA));
    send_item(mk(OP_EXTEND, 16'h7FFE, 32'h0));

    // steady climb in large raw steps, back to back
    write_cpr(16'd1000);
    gaps_on = 1'b0;
    send_item(mk(OP_CLEAR, 16'h0000, 32'h0));
    ramp_raw = '0;
    ramp_t   = 32'h4000_0000;
    for (int k = 1; k <= RAMP_ITEMS; k++) begin
      ramp_raw = ramp_raw + 16'd32767;
      if (k % 16 == 0) begin
        ramp_t = ramp_t + 32'd60000;
        send_item(mk(OP_SPEED, ramp_raw, ramp_t));
      end else begin
        send_item(mk(OP_EXTEND, ramp_raw, ramp_t));
      end
    end
    gaps_on = 1'b1;

    write_cpr(16'hFFFF);
    hold_off_req = 1'b1;
    run_phase(PHASE_ITEMS);
    write_cpr(16'h0000);
    run_phase(PHASE_ITEMS);
    write_cpr(16'd1);
    run_phase(PHASE_ITEMS);
    write_cpr(16'($urandom));
    run_phase(PHASE_ITEMS);
    write_cpr(16'd360);
    run_phase(PHASE_ITEMS);
    write_cpr(16'($urandom_range(2, 64)));
    run_phase(PHASE_ITEMS);

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
